// ===== rtl/mm_pkg.sv =====
// Shared types and constants for the fixed-point matrix multiplier.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int VAL_W     = 32;  // Q16.16 element width
    localparam int OP_W      = 2;
    localparam int POS_W     = 3;   // row / col fields
    localparam int CFG_W     = 4;   // dimension registers
    localparam int CFG_IDX_W = 2;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_LOAD_LEFT  = 2'd0;
    localparam t_op OP_LOAD_RIGHT = 2'd1;
    localparam t_op OP_MULTIPLY   = 2'd2;

    localparam t_cfg_idx CFG_LEFT_ROWS  = 2'd0;
    localparam t_cfg_idx CFG_LEFT_COLS  = 2'd1;
    localparam t_cfg_idx CFG_RIGHT_ROWS = 2'd2;
    localparam t_cfg_idx CFG_RIGHT_COLS = 2'd3;

    // Control tag that travels down the cell chain with each left element.
    typedef struct packed {
        logic valid;
        logic first;  // k == 0: restart the accumulator
        logic last;   // k == inner dimension - 1
    } t_mm_ctl;

endpackage

// ===== rtl/mm_cmd_if.sv =====
// Command channel: loads and multiply requests.
`timescale 1ns / 1ps

interface mm_cmd_if import mm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output row, output col,
                    output value, input ready);
    modport sink   (input valid, input operation, input row, input col,
                    input value, output ready);
endinterface

// ===== rtl/mm_res_if.sv =====
// Result channel: one product (or echoed) element per transaction.
`timescale 1ns / 1ps

interface mm_res_if import mm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic                    mismatch;

    modport source (output valid, output out_row, output out_col,
                    output out_value, output last, output mismatch, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input out_value, input last, input mismatch, output ready);
endinterface

// ===== rtl/matrix_multiply_core.sv =====
// Fixed-point matrix multiplier top level: sequencer, left store, cell chain.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+----------------------------------------
//  i_cmd     | in  | valid / ready       | operation, row, col, value (Q16.16)
//  o_res     | out | valid / ready       | out_row, out_col, out_value, last, mismatch
//  i_cfg_*   | in  | write enable only   | i_cfg_idx selects dims, i_cfg_data 4 bits
//
//  Loads leave the sequencer idle; i_cmd is ready only while the sequencer is idle.
//  Multiply: per result row, lc left elements are fed into the chain,
//  the cell chain drains, then rc accumulators unload through the
//  rounding/saturation stage.
//  Mismatch echo: each left element is read from the left store, then output.
//  Reset (synchronous) returns to idle and sets all dimensions to 8; stores
//  are not cleared. A stalled o_res freezes the unload; the output register
//  lets the next command be taken while the final result still waits.

module matrix_multiply_core import mm_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    mm_cmd_if.sink                i_cmd,
    mm_res_if.source              o_res
);

    localparam int IW    = $clog2(MAX_DIM);           // row/col/k index
    localparam int DW    = $clog2(MAX_DIM + 1);       // dimension count
    localparam int LA_W  = $clog2(MAX_DIM * MAX_DIM); // left store address
    localparam int ACC_W = 2 * VAL_W + $clog2(MAX_DIM);
    // round half up at the binary point; zero when there are no fraction bits
    localparam logic [ACC_W:0] RND = ((ACC_W + 1)'(1) << FRAC_BITS) >> 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_SETTLE,
        S_EMIT,
        S_MIS_RD,
        S_MIS_OUT
    } t_state;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_left_rows, r_left_cols, r_right_rows, r_right_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_rows  <= CFG_W'(8);
            r_left_cols  <= CFG_W'(8);
            r_right_rows <= CFG_W'(8);
            r_right_cols <= CFG_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_ROWS:  r_left_rows  <= i_cfg_data;
                CFG_LEFT_COLS:  r_left_cols  <= i_cfg_data;
                CFG_RIGHT_ROWS: r_right_rows <= i_cfg_data;
                CFG_RIGHT_COLS: r_right_cols <= i_cfg_data;
            endcase
        end
    end

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DW-1:0] dim_of(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    logic [DW-1:0] lr, lc, rr, rc;
    assign lr = dim_of(r_left_rows);
    assign lc = dim_of(r_left_cols);
    assign rr = dim_of(r_right_rows);
    assign rc = dim_of(r_right_cols);

    // ---------------- command decode ----------------
    t_state r_state;
    logic   cmd_acc, in_range, ld_left, ld_right, out_free;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign in_range    = (int'(i_cmd.row) < MAX_DIM) && (int'(i_cmd.col) < MAX_DIM);
    assign ld_left     = cmd_acc && (i_cmd.operation == OP_LOAD_LEFT) && in_range;
    assign ld_right    = cmd_acc && (i_cmd.operation == OP_LOAD_RIGHT) && in_range;

    // ---------------- left store ----------------
    logic [VAL_W-1:0] r_lmem [MAX_DIM * MAX_DIM];
    logic [VAL_W-1:0] r_rdata;
    logic [LA_W-1:0]  wr_addr, rd_addr;
    logic [IW-1:0]    r_r, r_k, r_c;

    assign wr_addr = LA_W'(i_cmd.row) * LA_W'(MAX_DIM) + LA_W'(i_cmd.col);
    assign rd_addr = LA_W'(r_r) * LA_W'(MAX_DIM) + LA_W'(r_k);

    always_ff @(posedge i_clk) begin
        if (ld_left) begin
            r_lmem[wr_addr] <= i_cmd.value;
        end
        r_rdata <= r_lmem[rd_addr];
    end

    // ---------------- cell chain ----------------
    t_mm_ctl                  r_iss;       // tag for the element in r_rdata
    logic [IW-1:0]            r_iss_k;
    t_mm_ctl                  c_ctl [MAX_DIM + 1];
    logic [IW-1:0]            c_k   [MAX_DIM];
    logic signed [VAL_W-1:0]  c_a   [MAX_DIM];
    logic signed [ACC_W-1:0]  c_acc [MAX_DIM + 1];
    logic                     shift, tail;

    assign c_ctl[0]       = r_iss;
    assign c_k[0]         = r_iss_k;
    assign c_a[0]         = r_rdata;
    assign c_acc[MAX_DIM] = '0;
    // last k has reached the far end of the chain
    assign tail           = c_ctl[MAX_DIM].valid && c_ctl[MAX_DIM].last;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        logic we_j;
        assign we_j = ld_right && (int'(i_cmd.col) == j);
        if (j < MAX_DIM - 1) begin : g_mid
            mm_cell #(.MAX_DIM(MAX_DIM), .ACC_W(ACC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_we    (we_j),
                .i_waddr (IW'(i_cmd.row)),
                .i_wdata (i_cmd.value),
                .i_ctl   (c_ctl[j]),
                .i_k     (c_k[j]),
                .i_a     (c_a[j]),
                .o_ctl   (c_ctl[j+1]),
                .o_k     (c_k[j+1]),
                .o_a     (c_a[j+1]),
                .i_shift (shift),
                .i_acc   (c_acc[j+1]),
                .o_acc   (c_acc[j])
            );
        end else begin : g_end
            mm_cell #(.MAX_DIM(MAX_DIM), .ACC_W(ACC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_we    (we_j),
                .i_waddr (IW'(i_cmd.row)),
                .i_wdata (i_cmd.value),
                .i_ctl   (c_ctl[j]),
                .i_k     (c_k[j]),
                .i_a     (c_a[j]),
                .o_ctl   (c_ctl[j+1]),
                .o_k     (),
                .o_a     (),
                .i_shift (shift),
                .i_acc   (c_acc[j+1]),
                .o_acc   (c_acc[j])
            );
        end
    end

    // ---------------- round and saturate (cell 0 accumulator) ----------------
    logic signed [ACC_W:0]   s_sum, s_sh;
    logic signed [VAL_W-1:0] sat_val;

    always_comb begin
        s_sum = {c_acc[0][ACC_W-1], c_acc[0]} + RND;
        s_sh  = s_sum >>> FRAC_BITS;
        if ((&s_sh[ACC_W:VAL_W-1]) || !(|s_sh[ACC_W:VAL_W-1])) begin
            sat_val = s_sh[VAL_W-1:0];
        end else if (s_sh[ACC_W]) begin
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // ---------------- sequencer and output register ----------------
    logic                    r_ov;
    logic [POS_W-1:0]        r_out_row, r_out_col;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_last, r_out_mis;
    logic                    r_end, k_end, c_end;

    assign out_free = !r_ov || o_res.ready;
    assign shift    = (r_state == S_EMIT) && out_free;
    assign r_end    = (DW'(r_r) + DW'(1)) == lr;
    assign k_end    = (DW'(r_k) + DW'(1)) == lc;
    assign c_end    = (DW'(r_c) + DW'(1)) == rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_iss   <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_c     <= '0;
        end else begin
            r_iss <= '0;
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc && (i_cmd.operation == OP_MULTIPLY)) begin
                        r_r     <= '0;
                        r_k     <= '0;
                        r_c     <= '0;
                        r_state <= (lc != rr) ? S_MIS_RD : S_FEED;
                    end
                end
                S_FEED: begin
                    // left element (r, k) is read now, enters cell 0 next
                    r_iss   <= '{valid: 1'b1, first: (r_k == '0), last: k_end};
                    r_iss_k <= r_k;
                    if (k_end) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (tail) begin
                        r_state <= S_SETTLE;
                    end
                end
                S_SETTLE: begin
                    // last product lands in the far accumulator this cycle
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_out_row   <= POS_W'(r_r);
                        r_out_col   <= POS_W'(r_c);
                        r_out_value <= sat_val;
                        r_out_last  <= r_end && c_end;
                        r_out_mis   <= 1'b0;
                        if (c_end) begin
                            r_c <= '0;
                            if (r_end) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_r     <= r_r + IW'(1);
                                r_state <= S_FEED;
                            end
                        end else begin
                            r_c <= r_c + IW'(1);
                        end
                    end
                end
                S_MIS_RD: begin
                    r_state <= S_MIS_OUT;
                end
                S_MIS_OUT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_out_row   <= POS_W'(r_r);
                        r_out_col   <= POS_W'(r_k);
                        r_out_value <= r_rdata;
                        r_out_last  <= r_end && k_end;
                        r_out_mis   <= 1'b1;
                        r_state     <= S_MIS_RD;
                        if (k_end) begin
                            r_k <= '0;
                            if (r_end) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_r <= r_r + IW'(1);
                            end
                        end else begin
                            r_k <= r_k + IW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;
    assign o_res.out_value = r_out_value;
    assign o_res.last      = r_out_last;
    assign o_res.mismatch  = r_out_mis;

endmodule

// ===== rtl/mm_cell.sv =====
// One column cell: right-matrix column bank, multiplier and accumulator.
`timescale 1ns / 1ps

module mm_cell import mm_pkg::*; #(
    parameter int MAX_DIM = 8,
    parameter int ACC_W   = 67
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // bank write (right matrix column)
    input  logic                         i_we,
    input  logic [$clog2(MAX_DIM)-1:0]   i_waddr,
    input  logic [VAL_W-1:0]             i_wdata,
    // left element stream from the upstream neighbor
    input  t_mm_ctl                      i_ctl,
    input  logic [$clog2(MAX_DIM)-1:0]   i_k,
    input  logic signed [VAL_W-1:0]      i_a,
    output t_mm_ctl                      o_ctl,
    output logic [$clog2(MAX_DIM)-1:0]   o_k,
    output logic signed [VAL_W-1:0]      o_a,
    // accumulator unload chain toward cell 0
    input  logic                         i_shift,
    input  logic signed [ACC_W-1:0]      i_acc,
    output logic signed [ACC_W-1:0]      o_acc
);

    logic [VAL_W-1:0]                 r_bank [MAX_DIM];
    t_mm_ctl                          r_ctl;
    t_mm_ctl                          r_pctl;
    logic [$clog2(MAX_DIM)-1:0]       r_k;
    logic signed [VAL_W-1:0]          r_a;
    logic signed [VAL_W-1:0]          r_b;
    logic signed [2*VAL_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]          r_acc;

    // bank and data path, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bank[i_waddr] <= i_wdata;
        end
        r_b    <= r_bank[i_k];
        r_a    <= i_a;
        r_k    <= i_k;
        r_prod <= r_a * r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_pctl <= '0;
        end else begin
            r_ctl  <= i_ctl;
            r_pctl <= r_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_shift) begin
            r_acc <= i_acc;
        end else if (r_pctl.valid) begin
            r_acc <= r_pctl.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    assign o_ctl = r_ctl;
    assign o_k   = r_k;
    assign o_a   = r_a;
    assign o_acc = r_acc;

endmodule

// ===== rtl/mm_checker.sv =====
// Port-level checks for the matrix multiplier, bound to the top level.
`timescale 1ns / 1ps

module mm_checker import mm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cmd_valid,
    input logic              i_cmd_ready,
    input logic [OP_W-1:0]   i_cmd_op,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [POS_W-1:0]  i_res_row,
    input logic [POS_W-1:0]  i_res_col,
    input logic [VAL_W-1:0]  i_res_value,
    input logic              i_res_last,
    input logic              i_res_mismatch
);

    logic cmd_acc;
    assign cmd_acc = i_cmd_valid && i_cmd_ready;

    // reset leaves the block idle with nothing to send
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && i_cmd_ready)
        else $error("not idle after reset");

    // a multiply closes the command side in the cycle after it is taken
    a_mul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && (i_cmd_op == OP_MULTIPLY) |=> !i_cmd_ready)
        else $error("command taken during multiply");

    // a load leaves the command side open in the cycle after it is taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && ((i_cmd_op == OP_LOAD_LEFT) || (i_cmd_op == OP_LOAD_RIGHT))
        |=> i_cmd_ready)
        else $error("load stalled the command channel");

    // a run is not over while one of its non-final elements still waits
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last |-> !i_cmd_ready)
        else $error("command channel reopened mid-run");

    // stalled result transaction holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable({i_res_row, i_res_col, i_res_value, i_res_last, i_res_mismatch}))
        else $error("result changed while stalled");

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cmd_valid    (i_cmd.valid),
    .i_cmd_ready    (i_cmd.ready),
    .i_cmd_op       (i_cmd.operation),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_row      (o_res.out_row),
    .i_res_col      (o_res.out_col),
    .i_res_value    (o_res.out_value),
    .i_res_last     (o_res.last),
    .i_res_mismatch (o_res.mismatch)
);
